### src/htd_pkg.sv
// shared constants for the huffman tree decoder
package htd_pkg;

	// symbol width of a tree node
	localparam int SYM_W = 8;

	// command codes
	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_DECODE = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// symbol of a fresh node and of the root after clear
	localparam logic [SYM_W-1:0] SYM_DASH = 8'd45;

endpackage

### src/huffman_tree_decoder_core.sv
// huffman tree decoder: top level with the command sequencer and root/walk registers
//
//  channel   signals                                         direction  handshake
//  -------   ----------------------------------------------  ---------  ---------------------
//  request   start, busy, opcode, code_bits, code_length,    in         taken when start & !busy
//            load_symbol, coded_bit
//  result    done, out_symbol, out_valid, store_full         out        one cycle on done
//
//  steps: clear and the unused opcode answer from idle; a decode first refetches the walk node
//  if a load dropped it, then follows the coded bit and reads the child node if there is one;
//  a load walks the code bits, each bit a dependent store read or write
//  reset: root links cleared, root symbol '-', walk at the root, allocator at node 1;
//  the node store itself is never swept, nodes are written as they are allocated
//  stalls: none on the result side, done is a one-cycle pulse
module huffman_tree_decoder_core #(
	parameter int NODE_COUNT   = 512,
	parameter int MAX_CODE_LEN = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                opcode,
	input  logic [31:0]               code_bits,
	input  logic [5:0]                code_length,
	input  logic [htd_pkg::SYM_W-1:0] load_symbol,
	input  logic                      coded_bit,
	output logic                      done,
	output logic [htd_pkg::SYM_W-1:0] out_symbol,
	output logic                      out_valid,
	output logic                      store_full
);

	// node index width, allocator width, code bit counter width
	localparam int AW  = $clog2(NODE_COUNT);
	localparam int NFW = $clog2(NODE_COUNT + 1);
	localparam int IW  = $clog2(MAX_CODE_LEN + 1);
	localparam int SW  = htd_pkg::SYM_W;
	// one node entry: {left, right, symbol}
	localparam int DW  = 2 * AW + SW;

	// sequencer states
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_LD_STEP  = 3'd1; // look at the next code bit
	localparam logic [2:0] S_LD_RD    = 3'd2; // child entry arrives from the store
	localparam logic [2:0] S_LD_NEW   = 3'd3; // write the freshly allocated node
	localparam logic [2:0] S_DC_FETCH = 3'd4; // refill the walk node cache
	localparam logic [2:0] S_DC_STEP  = 3'd5; // follow the coded bit
	localparam logic [2:0] S_DC_RD    = 3'd6; // child entry arrives, check for a leaf

	logic [2:0]     state_q;

	// root node lives in flops so clear does not touch the node store
	logic [AW-1:0]  root_left_q;
	logic [AW-1:0]  root_right_q;
	logic [SW-1:0]  root_sym_q;

	logic [NFW-1:0] next_free_q;
	logic [AW-1:0]  walk_q;

	// cached entry of the walk node, dropped by any load
	logic           wk_ok_q;
	logic [AW-1:0]  wk_left_q;
	logic [AW-1:0]  wk_right_q;
	logic [SW-1:0]  wk_sym_q;

	// load walk: current node and its entry
	logic [AW-1:0]  cur_idx_q;
	logic [AW-1:0]  cur_left_q;
	logic [AW-1:0]  cur_right_q;
	logic [SW-1:0]  cur_sym_q;
	logic [IW-1:0]  bits_left_q;

	// latched request fields
	logic [31:0]    code_bits_q;
	logic [SW-1:0]  load_symbol_q;
	logic           coded_bit_q;

	// address of the child being read
	logic [AW-1:0]  child_q;

	// result registers
	logic           done_q;
	logic [SW-1:0]  out_symbol_q;
	logic           out_valid_q;
	logic           store_full_q;

	// node store ports
	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	logic [DW-1:0]  mem_wdata;
	logic           mem_re;
	logic [AW-1:0]  mem_raddr;
	logic [DW-1:0]  mem_rdata;
	logic [AW-1:0]  rd_left;
	logic [AW-1:0]  rd_right;
	logic [SW-1:0]  rd_sym;

	logic           accept;
	logic           done_set;
	logic [6:0]     len7;
	logic [6:0]     max7;
	logic [6:0]     n7;
	logic [6:0]     pos7;
	logic           ld_bit;
	logic [AW-1:0]  ld_child;
	logic           store_is_full;
	logic [AW-1:0]  nf_idx;
	logic [AW-1:0]  dc_left;
	logic [AW-1:0]  dc_right;
	logic [SW-1:0]  dc_sym;
	logic [AW-1:0]  dc_child;
	logic           dc_leaf;
	logic           rd_leaf;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	// code length saturates at the maximum supported length
	assign len7 = {1'b0, code_length};
	assign max7 = 7'(MAX_CODE_LEN);
	assign n7   = (len7 > max7) ? max7 : len7;

	// current code bit, first bit at the top of the used length; bits above 31 read as zero
	assign pos7     = 7'(bits_left_q) - 7'd1;
	assign ld_bit   = (pos7 < 7'd32) ? code_bits_q[pos7[4:0]] : 1'b0;
	assign ld_child = ld_bit ? cur_right_q : cur_left_q;

	assign store_is_full = (next_free_q == NFW'(NODE_COUNT));
	assign nf_idx        = next_free_q[AW-1:0];

	// walk node entry: root from flops, anything else from the cache
	assign dc_left  = (walk_q == '0) ? root_left_q  : wk_left_q;
	assign dc_right = (walk_q == '0) ? root_right_q : wk_right_q;
	assign dc_sym   = (walk_q == '0) ? root_sym_q   : wk_sym_q;
	assign dc_child = coded_bit_q ? dc_right : dc_left;
	assign dc_leaf  = (dc_left == '0) && (dc_right == '0);

	assign rd_left  = mem_rdata[DW-1 -: AW];
	assign rd_right = mem_rdata[SW +: AW];
	assign rd_sym   = mem_rdata[SW-1:0];
	assign rd_leaf  = (rd_left == '0) && (rd_right == '0);

	// node store requests
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_idx_q;
		mem_wdata = {cur_left_q, cur_right_q, load_symbol_q};
		mem_re    = 1'b0;
		mem_raddr = walk_q;
		unique case (state_q)
			S_IDLE: begin
				// walk node cache was dropped by a load, fetch it again
				if (accept && (opcode == htd_pkg::OP_DECODE) && (walk_q != '0) && !wk_ok_q) begin
					mem_re = 1'b1;
				end
			end
			S_LD_STEP: begin
				if (bits_left_q == '0) begin
					// final node takes the symbol; the root is in flops
					mem_we = (cur_idx_q != '0);
				end else if (ld_child != '0) begin
					mem_re    = 1'b1;
					mem_raddr = ld_child;
				end else if (!store_is_full && (cur_idx_q != '0)) begin
					// hook the new node into a non-root parent
					mem_we    = 1'b1;
					mem_wdata = ld_bit ? {cur_left_q, nf_idx, cur_sym_q}
					                   : {nf_idx, cur_right_q, cur_sym_q};
				end
			end
			S_LD_NEW: begin
				mem_we    = 1'b1;
				mem_waddr = nf_idx;
				mem_wdata = {{AW{1'b0}}, {AW{1'b0}}, htd_pkg::SYM_DASH};
			end
			S_DC_STEP: begin
				if (dc_child != '0) begin
					mem_re    = 1'b1;
					mem_raddr = dc_child;
				end
			end
			S_LD_RD, S_DC_FETCH, S_DC_RD: begin
			end
			default: begin
			end
		endcase
	end

	// result strobe: the last cycle of every request
	always_comb begin
		done_set = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				// clear and the unused opcode answer at once
				done_set = accept && (opcode != htd_pkg::OP_LOAD)
				           && (opcode != htd_pkg::OP_DECODE);
			end
			S_LD_STEP: begin
				// code done, or stopped by a full store
				done_set = (bits_left_q == '0) || ((ld_child == '0) && store_is_full);
			end
			S_DC_STEP: begin
				done_set = (dc_child == '0);
			end
			S_DC_RD: begin
				done_set = 1'b1;
			end
			default: begin
				done_set = 1'b0;
			end
		endcase
	end

	htd_node_store #(
		.DEPTH (NODE_COUNT),
		.AW    (AW),
		.DW    (DW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			root_left_q  <= '0;
			root_right_q <= '0;
			root_sym_q   <= htd_pkg::SYM_DASH;
			next_free_q  <= NFW'(1);
			walk_q       <= '0;
			wk_ok_q      <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= done_set;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (opcode)
							htd_pkg::OP_LOAD: begin
								wk_ok_q <= 1'b0;
								state_q <= S_LD_STEP;
							end
							htd_pkg::OP_DECODE: begin
								if ((walk_q == '0) || wk_ok_q) begin
									state_q <= S_DC_STEP;
								end else begin
									state_q <= S_DC_FETCH;
								end
							end
							htd_pkg::OP_CLEAR: begin
								root_left_q  <= '0;
								root_right_q <= '0;
								root_sym_q   <= htd_pkg::SYM_DASH;
								next_free_q  <= NFW'(1);
								walk_q       <= '0;
								wk_ok_q      <= 1'b0;
							end
							default: begin
								// unused opcode: empty result
							end
						endcase
					end
				end
				S_LD_STEP: begin
					if (bits_left_q == '0) begin
						if (cur_idx_q == '0) begin
							root_sym_q <= load_symbol_q;
						end
						state_q <= S_IDLE;
					end else if (ld_child != '0) begin
						state_q <= S_LD_RD;
					end else if (store_is_full) begin
						state_q <= S_IDLE;
					end else begin
						if (cur_idx_q == '0) begin
							if (ld_bit) begin
								root_right_q <= nf_idx;
							end else begin
								root_left_q <= nf_idx;
							end
						end
						state_q <= S_LD_NEW;
					end
				end
				S_LD_RD: begin
					state_q <= S_LD_STEP;
				end
				S_LD_NEW: begin
					next_free_q <= next_free_q + NFW'(1);
					state_q     <= S_LD_STEP;
				end
				S_DC_FETCH: begin
					wk_ok_q <= 1'b1;
					state_q <= S_DC_STEP;
				end
				S_DC_STEP: begin
					if (dc_child != '0) begin
						state_q <= S_DC_RD;
					end else begin
						// missing child: stay, but a childless node still emits and returns the walk to the root
						if (dc_leaf) begin
							walk_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				S_DC_RD: begin
					if (rd_leaf) begin
						walk_q <= '0;
					end else begin
						walk_q  <= child_q;
						wk_ok_q <= 1'b1;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				code_bits_q   <= code_bits;
				load_symbol_q <= load_symbol;
				coded_bit_q   <= coded_bit;
				bits_left_q   <= n7[IW-1:0];
				cur_idx_q     <= '0;
				cur_left_q    <= root_left_q;
				cur_right_q   <= root_right_q;
				cur_sym_q     <= root_sym_q;
				out_symbol_q  <= '0;
				out_valid_q   <= 1'b0;
				store_full_q  <= 1'b0;
			end
			S_LD_STEP: begin
				child_q      <= ld_child;
				out_symbol_q <= '0;
				out_valid_q  <= 1'b0;
				store_full_q <= (bits_left_q != '0) && (ld_child == '0) && store_is_full;
			end
			S_LD_RD: begin
				cur_idx_q   <= child_q;
				cur_left_q  <= rd_left;
				cur_right_q <= rd_right;
				cur_sym_q   <= rd_sym;
				bits_left_q <= bits_left_q - IW'(1);
			end
			S_LD_NEW: begin
				cur_idx_q   <= nf_idx;
				cur_left_q  <= '0;
				cur_right_q <= '0;
				cur_sym_q   <= htd_pkg::SYM_DASH;
				bits_left_q <= bits_left_q - IW'(1);
			end
			S_DC_FETCH: begin
				wk_left_q  <= rd_left;
				wk_right_q <= rd_right;
				wk_sym_q   <= rd_sym;
			end
			S_DC_STEP: begin
				child_q      <= dc_child;
				store_full_q <= 1'b0;
				if ((dc_child == '0) && dc_leaf) begin
					out_symbol_q <= dc_sym;
					out_valid_q  <= 1'b1;
				end else begin
					out_symbol_q <= '0;
					out_valid_q  <= 1'b0;
				end
			end
			S_DC_RD: begin
				wk_left_q    <= rd_left;
				wk_right_q   <= rd_right;
				wk_sym_q     <= rd_sym;
				store_full_q <= 1'b0;
				if (rd_leaf) begin
					out_symbol_q <= rd_sym;
					out_valid_q  <= 1'b1;
				end else begin
					out_symbol_q <= '0;
					out_valid_q  <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign done       = done_q;
	assign out_symbol = out_symbol_q;
	assign out_valid  = out_valid_q;
	assign store_full = store_full_q;

`ifndef NO_ASSERTIONS
	// a result never reports a decoded symbol and a full store together
	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(out_valid && store_full))
		else $error("result flags both a symbol and a full store");

	// an accepted request either completes at once or keeps the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || done))
		else $error("accepted request neither busy nor done");

	// the allocator never runs past the end of the node store
	a_alloc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q <= NFW'(NODE_COUNT))
		else $error("node allocator beyond store depth");

	// a walk node other than the root is only followed with a valid cached entry
	a_walk_cache: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DC_STEP) |-> ((walk_q == '0) || wk_ok_q))
		else $error("decode step with a stale walk node entry");
`endif

endmodule

### src/htd_node_store.sv
// node store: one write port, one read port, registered read data
module htd_node_store #(
	parameter int DEPTH = 512,
	parameter int AW    = 9,
	parameter int DW    = 26
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
